// ===== rtl/core/swept_resonant_lowpass_top_assert.svh =====
// Assertion macros shared by the filter RTL.
`ifndef SWEPT_RESONANT_LOWPASS_TOP_ASSERT_SVH
`define SWEPT_RESONANT_LOWPASS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);
`else
`define SRLP_ASSERT(lbl, prop, msg)
`define SRLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/srlp_pkg.sv =====
package srlp_pkg;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic               restart;
    } t_in;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_DIV,
        UOP_FB,
        UOP_MUL_HI,
        UOP_MUL_LO,
        UOP_DIFF,
        UOP_UPD0,
        UOP_UPD1,
        UOP_UPD2,
        UOP_DONE
    } t_uop;

    typedef enum logic [1:0] {
        SRC_FB_S12,
        SRC_CUT_D,
        SRC_CUT_S01,
        SRC_CUT_S12
    } t_src;

    typedef struct packed {
        logic load;
        t_uop uop;
        t_src src;
        logic chan;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

    localparam logic [1:0] REG_CUTOFF_START = 2'd0;
    localparam logic [1:0] REG_CUTOFF_STEP  = 2'd1;
    localparam logic [1:0] REG_RESONANCE    = 2'd2;

    localparam logic signed [31:0] CUT_MIN = 32'sd168;
    localparam logic signed [31:0] CUT_MAX = 32'sd16760439;
    localparam logic [16:0]        FB_MAX  = 17'd58982;
    localparam logic signed [25:0] CUTOFF_START_RST = 26'sd8388608;

endpackage

// ===== rtl/core/srlp_div.sv =====
`include "swept_resonant_lowpass_top_assert.svh"
module srlp_div import srlp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_res,
    input  logic [24:0] i_den,
    output logic [15:0] o_q,
    output logic        o_ovf,
    output logic        o_done
);
    // restoring divide, one quotient bit per cycle; quotient >= 2^16 flags overflow
    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [39:0] r_rem;
    logic [39:0] r_dsh;
    logic [15:0] r_q;
    logic        r_ovf;
    logic        ge;

    assign ge = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {i_res, 24'd0};
            r_dsh <= {i_den, 15'd0};
            r_q   <= '0;
            r_ovf <= {1'b0, i_res, 24'd0} >= {i_den, 16'd0};
        end else if (r_busy) begin
            r_rem <= ge ? (r_rem - r_dsh) : r_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[14:0], ge};
        end
    end

    assign o_q    = r_q;
    assign o_ovf  = r_ovf;
    assign o_done = r_done;

    `SRLP_ASSERT(a_div_done_after_busy, r_done |-> $past(r_busy), "divider done without work")
    `SRLP_ASSERT(a_div_no_restart, i_start |-> !r_busy, "divider restarted while busy")
    `SRLP_ASSERT_NEXT(a_div_start, i_start, r_busy, "divider did not start")

endmodule

// ===== rtl/core/srlp_ctrl.sv =====
`include "swept_resonant_lowpass_top_assert.svh"
module srlp_ctrl import srlp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVGO,
        S_DIV,
        S_FB,
        S_RUN,
        S_OUT
    } t_state;

    localparam logic [3:0] LAST_STEP = 4'd11;

    t_state     r_state;
    logic [3:0] r_step;
    logic       r_chan;
    logic       accept;
    t_uop       run_uop;
    t_src       run_src;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // per-channel program: feedback product, input difference, three stage updates
    always_comb begin
        run_uop = UOP_NONE;
        run_src = SRC_FB_S12;
        case (r_step)
            4'd0:  begin run_uop = UOP_MUL_HI; run_src = SRC_FB_S12;  end
            4'd1:  begin run_uop = UOP_MUL_LO; run_src = SRC_FB_S12;  end
            4'd2:  begin run_uop = UOP_DIFF;   run_src = SRC_CUT_D;   end
            4'd3:  begin run_uop = UOP_MUL_HI; run_src = SRC_CUT_D;   end
            4'd4:  begin run_uop = UOP_MUL_LO; run_src = SRC_CUT_D;   end
            4'd5:  begin run_uop = UOP_UPD0;   run_src = SRC_CUT_D;   end
            4'd6:  begin run_uop = UOP_MUL_HI; run_src = SRC_CUT_S01; end
            4'd7:  begin run_uop = UOP_MUL_LO; run_src = SRC_CUT_S01; end
            4'd8:  begin run_uop = UOP_UPD1;   run_src = SRC_CUT_S01; end
            4'd9:  begin run_uop = UOP_MUL_HI; run_src = SRC_CUT_S12; end
            4'd10: begin run_uop = UOP_MUL_LO; run_src = SRC_CUT_S12; end
            4'd11: begin run_uop = UOP_UPD2;   run_src = SRC_CUT_S12; end
            default: begin run_uop = UOP_NONE; run_src = SRC_FB_S12; end
        endcase
    end

    always_comb begin
        o_cmd.load = accept;
        o_cmd.chan = r_chan;
        o_cmd.src  = run_src;
        o_cmd.uop  = UOP_NONE;
        case (r_state)
            S_DIVGO: o_cmd.uop = UOP_DIV;
            S_FB:    o_cmd.uop = UOP_FB;
            S_RUN:   o_cmd.uop = run_uop;
            S_OUT:   o_cmd.uop = i_sts.out_free ? UOP_DONE : UOP_NONE;
            default: o_cmd.uop = UOP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_chan  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_DIVGO;
                end
                S_DIVGO: r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_done) r_state <= S_FB;
                end
                S_FB: begin
                    r_step  <= '0;
                    r_chan  <= 1'b0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_step == LAST_STEP) begin
                        r_step <= '0;
                        r_chan <= 1'b1;
                        if (r_chan) r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `SRLP_ASSERT(a_ctrl_div_done_state, i_sts.div_done |-> (r_state == S_DIV),
        "divider finished outside its wait state")
    `SRLP_ASSERT(a_ctrl_step_range, (r_state == S_RUN) |-> (r_step <= LAST_STEP),
        "program step out of range")
    `SRLP_ASSERT_NEXT(a_ctrl_accept, accept, (r_state == S_DIVGO), "accept did not start work")

endmodule

// ===== rtl/core/srlp_dp.sv =====
module srlp_dp import srlp_pkg::*; #(
    parameter int STATE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_in                i_in,
    input  logic signed [25:0] i_cut_start,
    input  logic signed [24:0] i_cut_step,
    input  logic [15:0]        i_res,
    output t_out               o_out,
    output logic               o_div_done
);
    localparam int F   = STATE_FRAC_BITS;
    localparam int XW  = 16 + F;
    localparam int MW  = (XW > 34) ? XW : 34;
    localparam int BW  = MW + 2;
    localparam int LW  = BW / 2;
    localparam int HW  = BW - LW;
    localparam int PW  = 25 + BW;

    logic signed [31:0] r_ls [3];
    logic signed [31:0] r_rs [3];
    logic signed [31:0] r_cutnow;
    logic signed [15:0] r_xl, r_xr;
    logic [23:0]        r_cut;
    logic [15:0]        r_fb;
    logic signed [BW-1:0] r_d;
    logic signed [PW-1:0] r_acc;
    t_out               r_out;

    logic signed [31:0] s0, s1, s2, sk;
    logic signed [15:0] xc;
    logic signed [XW-1:0] xin;
    logic signed [32:0] d01, d12;
    logic signed [24:0] opa;
    logic signed [BW-1:0] opb;
    logic signed [25+HW-1:0] prod_hi;
    logic signed [25+LW:0]   prod_lo;
    logic signed [PW-1:0] dsum, usum;
    logic signed [31:0] usat;
    logic signed [31:0] cn;
    logic [23:0]        cut_cl;
    logic signed [32:0] csum;
    logic signed [31:0] csat;
    logic [15:0]        dq;
    logic               dovf;
    logic [16:0]        fsum;
    logic [24:0]        den;

    function automatic logic signed [15:0] trunc_sat(input logic signed [31:0] s);
        logic signed [32:0] adj;
        logic signed [32:0] sh;
        adj = {s[31], s} + (s[31] ? 33'((1 << F) - 1) : 33'd0);
        sh  = adj >>> F;
        if (sh > 33'sd32767)       trunc_sat = 16'sh7fff;
        else if (sh < -33'sd32768) trunc_sat = 16'sh8000;
        else                       trunc_sat = sh[15:0];
    endfunction

    assign s0 = i_cmd.chan ? r_rs[0] : r_ls[0];
    assign s1 = i_cmd.chan ? r_rs[1] : r_ls[1];
    assign s2 = i_cmd.chan ? r_rs[2] : r_ls[2];
    assign xc = i_cmd.chan ? r_xr : r_xl;
    assign xin = {xc, {F{1'b0}}};
    assign d01 = {s0[31], s0} - {s1[31], s1};
    assign d12 = {s1[31], s1} - {s2[31], s2};

    always_comb begin
        opa = $signed({1'b0, r_cut});
        opb = BW'(d12);
        case (i_cmd.src)
            SRC_FB_S12:  begin opa = $signed({9'd0, r_fb}); opb = BW'(d12); end
            SRC_CUT_D:   begin opa = $signed({1'b0, r_cut}); opb = r_d;     end
            SRC_CUT_S01: begin opa = $signed({1'b0, r_cut}); opb = BW'(d01); end
            SRC_CUT_S12: begin opa = $signed({1'b0, r_cut}); opb = BW'(d12); end
            default:     begin opa = $signed({1'b0, r_cut}); opb = BW'(d12); end
        endcase
    end

    // two-pass multiply: high part of B, then shifted accumulate of low part
    assign prod_hi = opa * $signed(opb[BW-1:LW]);
    assign prod_lo = opa * $signed({1'b0, opb[LW-1:0]});

    assign dsum = PW'(xin) - PW'(s0) + (r_acc >>> 16);

    always_comb begin
        case (i_cmd.uop)
            UOP_UPD1: sk = s1;
            UOP_UPD2: sk = s2;
            default:  sk = s0;
        endcase
    end

    assign usum = PW'(sk) + (r_acc >>> 24);
    always_comb begin
        if ((usum[PW-1:31] == '0) || (usum[PW-1:31] == '1)) usat = usum[31:0];
        else usat = usum[PW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end

    assign cn = i_in.restart ? 32'(i_cut_start) : r_cutnow;
    always_comb begin
        if (cn > CUT_MAX)      cut_cl = CUT_MAX[23:0];
        else if (cn < CUT_MIN) cut_cl = CUT_MIN[23:0];
        else                   cut_cl = cn[23:0];
    end

    assign csum = {r_cutnow[31], r_cutnow} + 33'(i_cut_step);
    always_comb begin
        if (csum[32] == csum[31]) csat = csum[31:0];
        else csat = csum[32] ? 32'sh80000000 : 32'sh7fffffff;
    end

    assign den  = 25'h1000000 - {1'b0, r_cut};
    assign fsum = {1'b0, i_res} + {1'b0, dq};

    srlp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.uop == UOP_DIV),
        .i_res   (i_res),
        .i_den   (den),
        .o_q     (dq),
        .o_ovf   (dovf),
        .o_done  (o_div_done)
    );

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_ls[i] <= '0;
                r_rs[i] <= '0;
            end
            r_cutnow <= 32'(CUTOFF_START_RST);
        end else begin
            if (i_cmd.load && i_in.restart) begin
                for (int i = 0; i < 3; i++) begin
                    r_ls[i] <= '0;
                    r_rs[i] <= '0;
                end
                r_cutnow <= 32'(i_cut_start);
            end
            case (i_cmd.uop)
                UOP_UPD0: begin
                    if (i_cmd.chan) r_rs[0] <= usat;
                    else            r_ls[0] <= usat;
                end
                UOP_UPD1: begin
                    if (i_cmd.chan) r_rs[1] <= usat;
                    else            r_ls[1] <= usat;
                end
                UOP_UPD2: begin
                    if (i_cmd.chan) r_rs[2] <= usat;
                    else            r_ls[2] <= usat;
                end
                UOP_DONE: r_cutnow <= csat;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xl  <= i_in.left_in;
            r_xr  <= i_in.right_in;
            r_cut <= cut_cl;
        end
        case (i_cmd.uop)
            UOP_FB:     r_fb  <= (dovf || (fsum > FB_MAX)) ? FB_MAX[15:0] : fsum[15:0];
            UOP_MUL_HI: r_acc <= PW'(prod_hi);
            UOP_MUL_LO: r_acc <= (r_acc <<< LW) + PW'(prod_lo);
            UOP_DIFF:   r_d   <= dsum[BW-1:0];
            UOP_DONE: begin
                r_out.left_out  <= trunc_sat(r_ls[2]);
                r_out.right_out <= trunc_sat(r_rs[2]);
            end
            default: ;
        endcase
    end

    assign o_out = r_out;

endmodule

// ===== rtl/core/swept_resonant_lowpass_top.sv =====
// Stereo three-pole resonant lowpass with a linearly swept cutoff. One input
// transfer (left, right, restart) yields one output transfer (left, right),
// in order. For each sample a restoring divider forms resonance/(1 - cutoff),
// which is added to resonance to give the feedback factor, then one shared
// two-pass multiplier runs 24 steps (12 per channel) of feedback and stage
// updates. Items are processed one at a time; the finished pair sits in an
// output register, so the next input transfer is taken while it waits.
// Registers (APB, 32-bit words): 0x0 cutoff_start (26-bit signed, 2^-24
// units, loaded on restart), 0x4 cutoff_step (25-bit signed, added after
// every sample), 0x8 resonance (16-bit, 2^-16 units; feedback limited to
// 0.9). Write registers only while the block is idle.
`include "swept_resonant_lowpass_top_assert.svh"
module swept_resonant_lowpass_top import srlp_pkg::*; #(
    parameter int STATE_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic signed [25:0] r_cut_start;
    logic signed [24:0] r_cut_step;
    logic [15:0]        r_res;
    logic               r_ovalid;
    logic               cfg_wr;
    logic               busy;
    logic               out_load;
    t_cmd               cmd;
    t_sts               sts;
    logic               div_done;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_start <= CUTOFF_START_RST;
            r_cut_step  <= '0;
            r_res       <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_CUTOFF_START: r_cut_start <= pwdata[25:0];
                REG_CUTOFF_STEP:  r_cut_step  <= pwdata[24:0];
                REG_RESONANCE:    r_res       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CUTOFF_START: prdata = 32'(r_cut_start);
            REG_CUTOFF_STEP:  prdata = 32'(r_cut_step);
            REG_RESONANCE:    prdata = {16'd0, r_res};
            default:          prdata = '0;
        endcase
    end

    // output register is free when empty or when its transfer completes now
    assign sts.out_free = !r_ovalid || !i_out_stall;
    assign sts.div_done = div_done;
    assign out_load     = (cmd.uop == UOP_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    srlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    srlp_dp #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in_data),
        .i_cut_start (r_cut_start),
        .i_cut_step  (r_cut_step),
        .i_res       (r_res),
        .o_out       (o_out_data),
        .o_div_done  (div_done)
    );

    assign o_in_stall  = busy;
    assign o_out_valid = r_ovalid;

    `SRLP_ASSERT(a_top_no_overwrite, out_load |-> (!r_ovalid || !i_out_stall),
        "result loaded over a pending transfer")
    `SRLP_ASSERT(a_top_accept_idle, (i_in_valid && !o_in_stall) |-> !out_load,
        "input taken while a result is being finished")
    `SRLP_ASSERT_NEXT(a_top_load_shows, out_load, o_out_valid, "finished result not shown")

endmodule
